>>> hw/rtl/rotation_matrix_to_euler_angles_defines.svh
// Assertion macros used by the top-level RTL file.
`ifndef ROTATION_MATRIX_TO_EULER_ANGLES_DEFINES_SVH
`define ROTATION_MATRIX_TO_EULER_ANGLES_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define RME_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define RME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/rme_pkg.sv
package rme_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned AtanEntries    = 24;
  localparam int unsigned ZW             = 28;
  localparam int unsigned XW             = 28;
  localparam int unsigned RootSteps      = 16;
  localparam int unsigned QueueDepth     = 4;
  localparam logic signed [ZW-1:0] PiUnits = 28'sd52707179;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r10;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic               gimbal_lock;
  } out_req_t;

  // Classified request handed from the front part to the back part.
  // Operands carry 17 bits so that a negated -32768 and a root above
  // 32767 keep their values.
  typedef struct packed {
    logic signed [16:0] roll_y;
    logic signed [16:0] roll_x;
    logic signed [16:0] pitch_y;
    logic signed [16:0] pitch_x;
    logic signed [16:0] yaw_y;
    logic signed [16:0] yaw_x;
    logic               singular;
  } job_t;

  // atan(2^-i) in units of 2^-24 rad.
  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = 28'sd13176795;
      5'd1:  v = 28'sd7778716;
      5'd2:  v = 28'sd4110060;
      5'd3:  v = 28'sd2086331;
      5'd4:  v = 28'sd1047214;
      5'd5:  v = 28'sd524117;
      5'd6:  v = 28'sd262123;
      5'd7:  v = 28'sd131069;
      5'd8:  v = 28'sd65536;
      5'd9:  v = 28'sd32768;
      5'd10: v = 28'sd16384;
      5'd11: v = 28'sd8192;
      5'd12: v = 28'sd4096;
      5'd13: v = 28'sd2048;
      5'd14: v = 28'sd1024;
      5'd15: v = 28'sd512;
      5'd16: v = 28'sd256;
      5'd17: v = 28'sd128;
      5'd18: v = 28'sd64;
      5'd19: v = 28'sd32;
      5'd20: v = 28'sd16;
      5'd21: v = 28'sd8;
      5'd22: v = 28'sd4;
      5'd23: v = 28'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/rotation_matrix_to_euler_angles.sv
// Channel  Direction  Payload
// in_      input      seven Q1.14 matrix elements (rme_pkg::in_req_t)
// out_     output     roll, pitch, yaw Q2.13 and gimbal flag (rme_pkg::out_req_t)
// cfg_     input      singular threshold, 15 bits Q1.14
// One request enters per cycle while in_stall is low; the squares are taken at
// the accepting edge, then 16 root stages, the queue write, the CORDIC entry
// stage and CORDIC_STEPS stages (at most 24) follow before out_valid rises.
// Reset is synchronous and active low and clears all valid flags.
// An output stall holds the CORDIC pipeline; the queue absorbs the front
// pipeline's requests in flight, and in_stall rises once it holds four requests.
`include "rotation_matrix_to_euler_angles_defines.svh"
module rotation_matrix_to_euler_angles #(
  parameter int unsigned CORDIC_STEPS = rme_pkg::CordicStepsDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rme_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rme_pkg::out_req_t out_data,
  input  logic              cfg_we,
  input  logic [14:0]       cfg_data
);

  // Queue must hold every request in the front pipeline plus its own margin.
  localparam int unsigned QD = rme_pkg::RootSteps + 1 + rme_pkg::QueueDepth;
  localparam int unsigned CW = $clog2(QD + 1);

  logic [14:0] thresh_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= 15'd1;
    end else if (cfg_we) begin
      thresh_r <= cfg_data;
    end
  end

  logic                     f_vld;
  rme_pkg::job_t            f_job;
  logic                     q_vld;
  rme_pkg::job_t            q_job;
  logic [CW-1:0]            q_cnt;
  logic                     b_adv;
  logic                     q_rd;
  logic                     room;

  // Requests are taken while the queue has room for all in flight; the front never stalls.
  assign room     = q_cnt <= CW'(QD - rme_pkg::RootSteps - 2);
  assign in_stall = !room;

  rme_front u_front (
    .clk, .rst_n,
    .thresh  (thresh_r),
    .adv     (1'b1),
    .in_vld  (in_valid && room),
    .in_data (in_data),
    .job_vld (f_vld),
    .job     (f_job)
  );

  rme_queue #(.DEPTH(QD)) u_queue (
    .clk, .rst_n,
    .wr_en   (f_vld),
    .wr_data (f_job),
    .rd_en   (q_rd),
    .rd_vld  (q_vld),
    .rd_data (q_job),
    .count   (q_cnt)
  );

  assign b_adv = !(out_valid && out_stall);
  assign q_rd  = q_vld && b_adv;

  rme_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst_n,
    .adv     (b_adv),
    .in_vld  (q_rd),
    .job     (q_job),
    .out_vld (out_valid),
    .res     (out_data)
  );

  `RME_ASSERT_IMPL(a_no_overflow, clk, rst_n, f_vld, q_cnt < CW'(QD), "queue overflow")
  `RME_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped")
  `RME_ASSERT_IMPL(a_yaw_zero, clk, rst_n, out_valid && out_data.gimbal_lock, out_data.yaw == 16'sd0, "yaw not zero")
  `RME_ASSERT_NEXT(a_cfg, clk, rst_n, cfg_we, thresh_r == $past(cfg_data), "threshold not written")

endmodule

>>> hw/rtl/rme_front.sv
// Front part: squares, pipelined square root and branch selection.
module rme_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [14:0]        thresh,
  input  logic               adv,
  input  logic               in_vld,
  input  rme_pkg::in_req_t   in_data,
  output logic               job_vld,
  output rme_pkg::job_t      job
);

  localparam int unsigned NS = rme_pkg::RootSteps;

  // Stage 0: squares of r00 and r10 from the first column.
  logic              sq_vld_r;
  rme_pkg::in_req_t  sq_req_r;
  logic [31:0]       sq0_r, sq1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
    end else if (adv) begin
      sq_vld_r <= in_vld;
    end
    if (adv) begin
      sq_req_r <= in_data;
      sq0_r    <= 32'(in_data.r00 * in_data.r00);
      sq1_r    <= 32'(in_data.r10 * in_data.r10);
    end
  end

  // Root pipeline, one result bit per stage.
  logic              rt_vld_r [NS+1];
  rme_pkg::in_req_t  rt_req_r [NS+1];
  logic [33:0]       rt_rem_r [NS+1];
  logic [16:0]       rt_root_r[NS+1];

  always_comb begin
    rt_vld_r[0]  = sq_vld_r;
    rt_req_r[0]  = sq_req_r;
    rt_rem_r[0]  = 34'(sq0_r) + 34'(sq1_r);
    rt_root_r[0] = '0;
  end

  for (genvar s = 0; s < NS; s++) begin : g_root
    logic [33:0] trial;
    logic [33:0] bitv;
    // The trial adds twice the partial root times the new bit plus its square.
    assign bitv  = 34'(1) << (2 * (NS - 1 - s));
    assign trial = (34'(rt_root_r[s]) << (2 * (NS - s))) + bitv;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_vld_r[s+1] <= 1'b0;
      end else if (adv) begin
        rt_vld_r[s+1] <= rt_vld_r[s];
      end
      if (adv) begin
        rt_req_r[s+1] <= rt_req_r[s];
        if (rt_rem_r[s] >= trial) begin
          rt_rem_r[s+1]  <= rt_rem_r[s] - trial;
          rt_root_r[s+1] <= {rt_root_r[s][15:0], 1'b1};
        end else begin
          rt_rem_r[s+1]  <= rt_rem_r[s];
          rt_root_r[s+1] <= {rt_root_r[s][15:0], 1'b0};
        end
      end
    end
  end

  // Classification into operand pairs.
  logic [16:0] sy;
  logic        sing;
  assign sy   = rt_root_r[NS];
  assign sing = sy < 17'(thresh);

  always_comb begin
    job_vld     = rt_vld_r[NS];
    job.singular = sing;
    job.pitch_y = -17'(rt_req_r[NS].r20);
    job.pitch_x = signed'(sy);
    job.roll_y  = sing ? -17'(rt_req_r[NS].r12) : 17'(rt_req_r[NS].r21);
    job.roll_x  = sing ? 17'(rt_req_r[NS].r11) : 17'(rt_req_r[NS].r22);
    job.yaw_y   = sing ? 17'sd0 : 17'(rt_req_r[NS].r10);
    job.yaw_x   = sing ? 17'sd0 : 17'(rt_req_r[NS].r00);
  end

endmodule

>>> hw/rtl/rme_queue.sv
// Short queue between front and back parts.
module rme_queue #(
  parameter int unsigned DEPTH = rme_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  rme_pkg::job_t  wr_data,
  input  logic           rd_en,
  output logic           rd_vld,
  output rme_pkg::job_t  rd_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  rme_pkg::job_t              mem_r [DEPTH];
  logic [AW-1:0]              wp_r, rp_r;
  logic [$clog2(DEPTH+1)-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (wr_en ? 1'b1 : 1'b0) - (rd_en ? 1'b1 : 1'b0);
    end
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  assign rd_vld  = cnt_r != '0;
  assign rd_data = mem_r[rp_r];
  assign count   = cnt_r;

endmodule

>>> hw/rtl/rme_cordic.sv
// Vectoring CORDIC pipeline for three atan2 lanes.
module rme_cordic #(
  parameter int unsigned STEPS = rme_pkg::CordicStepsDef
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_vld,
  input  rme_pkg::job_t  job,
  output logic           out_vld,
  output rme_pkg::out_req_t res
);

  localparam int unsigned NS = (STEPS < rme_pkg::AtanEntries) ? STEPS
                                                               : rme_pkg::AtanEntries;
  localparam int unsigned XW = rme_pkg::XW;
  localparam int unsigned ZW = rme_pkg::ZW;

  logic                     vld_r [NS+1];
  logic                     sg_r  [NS+1];
  logic signed [XW-1:0]     x_r   [3][NS+1];
  logic signed [XW-1:0]     y_r   [3][NS+1];
  logic signed [ZW-1:0]     z_r   [3][NS+1];
  logic                     zero_r[3][NS+1];

  logic signed [16:0] ay [3];
  logic signed [16:0] ax [3];
  assign ay[0] = job.roll_y;  assign ax[0] = job.roll_x;
  assign ay[1] = job.pitch_y; assign ax[1] = job.pitch_x;
  assign ay[2] = job.yaw_y;   assign ax[2] = job.yaw_x;

  // Entry stage: scale, fold the left half plane.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
    end
    if (adv) begin
      sg_r[0] <= job.singular;
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [XW-1:0] xs, ys;
    assign xs = XW'(ax[l]) <<< 8;
    assign ys = XW'(ay[l]) <<< 8;
    always_ff @(posedge clk) begin
      if (adv) begin
        zero_r[l][0] <= (ax[l] == 17'sd0) && (ay[l] == 17'sd0);
        if (ax[l] < 0) begin
          x_r[l][0] <= -xs;
          y_r[l][0] <= -ys;
          z_r[l][0] <= (ay[l] >= 0) ? rme_pkg::PiUnits : -rme_pkg::PiUnits;
        end else begin
          x_r[l][0] <= xs;
          y_r[l][0] <= ys;
          z_r[l][0] <= '0;
        end
      end
    end
    for (genvar s = 0; s < NS; s++) begin : g_step
      logic signed [XW-1:0] xsh, ysh;
      assign xsh = x_r[l][s] >>> s;
      assign ysh = y_r[l][s] >>> s;
      always_ff @(posedge clk) begin
        if (adv) begin
          zero_r[l][s+1] <= zero_r[l][s];
          if (y_r[l][s] > 0) begin
            x_r[l][s+1] <= x_r[l][s] + ysh;
            y_r[l][s+1] <= y_r[l][s] - xsh;
            z_r[l][s+1] <= z_r[l][s] + rme_pkg::atan_lut(5'(s));
          end else begin
            x_r[l][s+1] <= x_r[l][s] - ysh;
            y_r[l][s+1] <= y_r[l][s] + xsh;
            z_r[l][s+1] <= z_r[l][s] - rme_pkg::atan_lut(5'(s));
          end
        end
      end
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (adv) begin
        vld_r[s+1] <= vld_r[s];
      end
      if (adv) begin
        sg_r[s+1] <= sg_r[s];
      end
    end
  end

  // Round to Q2.13.
  logic signed [ZW-1:0] zr [3];
  logic signed [15:0]   ang[3];
  for (genvar l = 0; l < 3; l++) begin : g_rnd
    assign zr[l]  = (z_r[l][NS] + signed'(ZW'(1024))) >>> 11;
    assign ang[l] = zero_r[l][NS] ? 16'sd0 : zr[l][15:0];
  end

  assign out_vld         = vld_r[NS];
  assign res.roll        = ang[0];
  assign res.pitch       = ang[1];
  assign res.yaw         = ang[2];
  assign res.gimbal_lock = sg_r[NS];

endmodule

>>> bench/rotation_matrix_to_euler_angles_tb.sv
module rotation_matrix_to_euler_angles_tb;

  localparam int unsigned Steps       = 16;
  localparam int unsigned LatencyCyc  = 18 + Steps;
  localparam int unsigned RandomItems = 1800;
  localparam longint      PiQ24       = 64'sd52707179;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  rme_pkg::in_req_t  in_data;
  logic     out_valid;
  logic     out_stall;
  rme_pkg::out_req_t out_data;
  logic     cfg_we;
  logic [14:0] cfg_data;

  rotation_matrix_to_euler_angles #(.CORDIC_STEPS(Steps)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // Clock with a period of 12.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state and the store of expected angles.
  logic [14:0] threshold_q;
  rme_pkg::out_req_t angles_expected[$];
  int          mismatch_count;
  int          result_count;
  int          lock_count;
  int          sent_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_receiver;

  // Floor shift right for signed values.
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  // Exact floor square root of a non-negative integer.
  function automatic longint isqrt(longint n);
    longint rem;
    longint root;
    longint b;
    rem  = n;
    root = 0;
    b    = 64'sd1 << 32;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // Vectoring CORDIC atan2 of Q1.14 operands, rounded to Q2.13.
  function automatic logic [15:0] cordic_atan2(longint y, longint x);
    longint z;
    longint xs;
    longint ys;
    longint xt;
    if (x == 0 && y == 0) return 16'd0;
    z = 0;
    x = x * 256;
    y = y * 256;
    if (x < 0) begin
      z = (y >= 0) ? PiQ24 : -PiQ24;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < Steps && i < 24; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      xt = longint'(rme_pkg::atan_lut(5'(i)));
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + xt;
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - xt;
      end
    end
    return 16'(floor_shr(z + 1024, 11));
  endfunction

  // Works out the Euler angles of one matrix under the current threshold.
  function automatic rme_pkg::out_req_t euler_of(rme_pkg::in_req_t m);
    rme_pkg::out_req_t r;
    longint   sy;
    sy = isqrt(longint'(m.r00) * m.r00 + longint'(m.r10) * m.r10);
    r.pitch = cordic_atan2(-longint'(m.r20), sy);
    if (sy >= longint'(threshold_q)) begin
      r.roll        = cordic_atan2(m.r21, m.r22);
      r.yaw         = cordic_atan2(m.r10, m.r00);
      r.gimbal_lock = 1'b0;
    end else begin
      r.roll        = cordic_atan2(-longint'(m.r12), m.r11);
      r.yaw         = 16'd0;
      r.gimbal_lock = 1'b1;
    end
    return r;
  endfunction

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    rme_pkg::out_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      result_count <= result_count + 1;
      if (angles_expected.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = angles_expected.pop_front();
        if (want.gimbal_lock) lock_count <= lock_count + 1;
        if (out_data !== want) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10)
            $display("mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  // Receiver stall, random or held off for a long stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_receiver) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Long hold-off of the receiver, counted in cycles.
  task automatic hold_off(int cycles);
    hold_receiver = 1'b1;
    repeat (cycles) @(posedge clk);
    hold_receiver = 1'b0;
  endtask

  // Offers one request and waits for it to be taken.
  task automatic send_matrix(rme_pkg::in_req_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= m;
    angles_expected.push_back(euler_of(m));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  // Waits until every expected result has come, then lets the pipe drain.
  task automatic drain;
    in_valid <= 1'b0;
    while (angles_expected.size() != 0) @(posedge clk);
    repeat (LatencyCyc + 4) @(posedge clk);
  endtask

  task automatic write_threshold(logic [14:0] v);
    cfg_we      <= 1'b1;
    cfg_data    <= v;
    threshold_q = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_elem();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 16'($urandom);
    if (pick == 1) return 16'($urandom_range(2)) * 16'sd16384 - 16'sd16384;
    if (pick == 2) return 16'($urandom_range(8)) - 16'sd4;
    return 16'($urandom_range(32768)) - 16'sd16384;
  endfunction

  // Random elements; one time in four r00 and r10 are made small (near-singular).
  function automatic rme_pkg::in_req_t rand_matrix();
    rme_pkg::in_req_t m;
    m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(),
         rand_elem(), rand_elem(), rand_elem()};
    if ($urandom_range(3) == 0) begin
      m.r00 = 16'($urandom_range(600)) - 16'sd300;
      m.r10 = 16'($urandom_range(600)) - 16'sd300;
    end
    return m;
  endfunction

  // Directed table: a typed expectation where it is plain, else predicted.
  typedef struct {
    rme_pkg::in_req_t  m;
    bit                typed;
    rme_pkg::out_req_t want;
  } vector_t;

  localparam logic signed [15:0] One = 16'sd16384;
  localparam logic signed [15:0] Mn  = -16'sd16384;

  vector_t directed[$];

  initial begin
    rme_pkg::out_req_t pred;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    hold_receiver = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    result_count = 0;
    lock_count = 0;
    sent_count = 0;
    threshold_q = 15'd1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity, all zero, axis flips, both extremes, 45-degree, tiny and zero-argument cases.
    directed.push_back('{'{One, 0, 0, 0, One, One, 0}, 1'b1, '{0, 0, 0, 1'b0}});
    directed.push_back('{'{0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 1'b1}});
    directed.push_back('{'{Mn, 0, 0, 0, One, One, 0}, 1'b0, '0});
    directed.push_back('{'{Mn, 0, 0, 0, Mn, Mn, 0}, 1'b0, '0});
    directed.push_back('{'{0, One, Mn, 0, 0, 0, 0}, 1'b0, '0});
    directed.push_back('{'{0, 0, One, One, Mn, 0, One}, 1'b0, '0});
    directed.push_back('{'{0, 0, Mn, Mn, 0, Mn, Mn}, 1'b0, '0});
    directed.push_back('{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                           -16'sd32768, -16'sd32768, -16'sd32768}, 1'b0, '0});
    directed.push_back('{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                           16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, '0});
    directed.push_back('{'{0, 0, 16'sd11585, 0, 0, 16'sd11585, -16'sd11585},
                         1'b0, '0});
    directed.push_back('{'{16'sd11585, -16'sd11585, 0, 16'sd11585, 16'sd11585,
                           0, 0}, 1'b0, '0});
    directed.push_back('{'{1, 0, 0, 1, 0, -1, 1}, 1'b0, '0});
    foreach (directed[i]) begin
      send_matrix(directed[i].m);
      if (directed[i].typed) begin
        pred = angles_expected[angles_expected.size() - 1];
        if (pred !== directed[i].want) begin
          mismatch_count++;
          $display("table row %0d: typed %p, predicted %p", i,
                   directed[i].want, pred);
        end
      end
    end
    drain();

    // Random phases over several thresholds and idling patterns.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_threshold(15'd0);
        1: write_threshold(15'd16384);
        2: write_threshold(15'($urandom_range(16384)));
        3: write_threshold(15'd200);
        4: write_threshold(15'h7fff);
        default: write_threshold(15'd1);
      endcase
      send_idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? (ph == 3 ? 19 : 85) : 0;
      recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? (ph == 3 ? 19 : 85) : 0;
      fork
        if (ph == 4) hold_off(300);
        for (int k = 0; k < RandomItems / 6; k++) send_matrix(rand_matrix());
      join
      drain();
    end

    $display("Sent %0d matrices, checked %0d results (%0d in gimbal lock),",
             sent_count, result_count, lock_count);
    $display("over six thresholds including 0 and the maximum, with stalls.");
    if (mismatch_count == 0 && angles_expected.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/rme_pkg.sv
hw/rtl/rme_front.sv
hw/rtl/rme_queue.sv
hw/rtl/rme_cordic.sv
hw/rtl/rotation_matrix_to_euler_angles.sv
bench/rotation_matrix_to_euler_angles_tb.sv
